FILE: design/ucpe_pkg.sv
// Shared types, constants and character helpers for the URI component percent encoder.
// No dependencies; used by ucpe_front, ucpe_queue, ucpe_back and the top level.
`default_nettype none

package ucpe_pkg;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Per-item push list (prefix separator, body, suffix separators)
  localparam int MAX_PUSH   = 4;
  localparam int PUSH_IDX_W = $clog2(MAX_PUSH);
  localparam int PUSH_CNT_W = PUSH_IDX_W + 1;

  // Per-item output list
  localparam int MAX_OUT   = 8;
  localparam int OUT_IDX_W = $clog2(MAX_OUT);
  localparam int OUT_CNT_W = OUT_IDX_W + 1;

  // Component kinds
  typedef enum logic [2:0] {
    FUNC_SCHEME   = 3'd0,
    FUNC_USERINFO = 3'd1,
    FUNC_PORT     = 3'd2,
    FUNC_PATH     = 3'd3,
    FUNC_QUERY    = 3'd4,
    FUNC_FRAGMENT = 3'd5
  } func_t;

  // Characters
  localparam logic [7:0] CH_PCT    = 8'h25; // %
  localparam logic [7:0] CH_DASH   = 8'h2D; // -
  localparam logic [7:0] CH_DOT    = 8'h2E; // .
  localparam logic [7:0] CH_US     = 8'h5F; // _
  localparam logic [7:0] CH_TILDE  = 8'h7E; // ~
  localparam logic [7:0] CH_SLASH  = 8'h2F; // /
  localparam logic [7:0] CH_QMARK  = 8'h3F; // ?
  localparam logic [7:0] CH_HASH   = 8'h23; // #
  localparam logic [7:0] CH_AT     = 8'h40; // @
  localparam logic [7:0] CH_COLON  = 8'h3A; // :
  localparam logic [7:0] CH_LBRACK = 8'h5B; // [
  localparam logic [7:0] CH_RBRACK = 8'h5D; // ]
  localparam logic [7:0] CH_BANG   = 8'h21; // !
  localparam logic [7:0] CH_DOLLAR = 8'h24; // $
  localparam logic [7:0] CH_AMP    = 8'h26; // &
  localparam logic [7:0] CH_APOS   = 8'h27; // '
  localparam logic [7:0] CH_LPAREN = 8'h28; // (
  localparam logic [7:0] CH_RPAREN = 8'h29; // )
  localparam logic [7:0] CH_STAR   = 8'h2A; // *
  localparam logic [7:0] CH_PLUS   = 8'h2B; // +
  localparam logic [7:0] CH_COMMA  = 8'h2C; // ,
  localparam logic [7:0] CH_SEMI   = 8'h3B; // ;
  localparam logic [7:0] CH_EQUAL  = 8'h3D; // =

  // One queue entry: bytes to push through the hold window, in order
  typedef struct packed {
    logic [MAX_PUSH-1:0][7:0] bytes;
    logic [PUSH_CNT_W-1:0]    count;
    logic                     eou;
    logic                     bad;
  } push_list_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

`default_nettype wire

FILE: design/uri_component_percent_encoder_core.sv
// Path: an accepted input byte is stored in the queue, then in the output buffer, then
//   in the registered output port. Throughput: one output byte per cycle from the back
//   part while m_tready is high; an item gives 0 to 6 bytes, typically 3 for %XX.
// Reset (rst, synchronous, active high): clears the error flag, the hold window, the
//   4-entry queue and the output valid. Data registers are not reset.
// Top level: ucpe_front -> ucpe_queue -> ucpe_back. Depends on ucpe_pkg.
`default_nettype none

module uri_component_percent_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream, one raw component byte per transaction
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // in_byte[7:0], first_of_part[8], lead_slash[9],
                                     // end_of_uri[10], zero[15:11]
  input  wire logic        s_tlast,  // last_of_part
  input  wire logic [2:0]  s_tuser,  // func
  // output stream, one encoded character per transaction
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // out_byte[7:0]
  output logic             m_tlast,  // run_last
  output logic [1:0]       m_tuser   // uri_done[0], bad_uri[1]
);

  // front -> queue
  logic                  wr_valid;
  logic                  wr_ready;
  ucpe_pkg::push_list_t  wr_data;
  // queue -> back
  logic                  rd_valid;
  logic                  rd_ready;
  ucpe_pkg::push_list_t  rd_data;

  // Front: classifies each byte for its component, inserts separators, builds
  // up to four bytes to push, tracks the sticky error flag.
  ucpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data)
  );

  // Queue lets the front keep accepting while the back expands an escape.
  ucpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  // Back: hold window for passed-through %xy, flush at end of URI, and
  // output serializer feeding the registered master side.
  ucpe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: design/ucpe_front.sv
// Front part: accepts input transactions, classifies the byte per component kind,
// builds the push list and keeps the sticky error flag. Depends on ucpe_pkg.
`default_nettype none

module ucpe_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [15:0]           s_tdata,  // in_byte[7:0], first_of_part, lead_slash, end_of_uri
  input  wire logic                  s_tlast,  // last_of_part
  input  wire logic [2:0]            s_tuser,  // func
  output logic                       wr_valid,
  input  wire logic                  wr_ready,
  output ucpe_pkg::push_list_t       wr_data
);

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_UNRES,
    CLS_PCT,
    CLS_GEN,
    CLS_SUB
  } class_t;

  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_ONE,
    BODY_HEX
  } body_t;

  typedef enum logic [1:0] {
    SUF_NONE,
    SUF_SCHEME,
    SUF_AT
  } suf_t;

  function automatic class_t byte_class(input logic [7:0] b);
    class_t c;
    c = CLS_OTHER;
    if (ucpe_pkg::is_letter(b) || ucpe_pkg::is_digit(b)) begin
      c = CLS_UNRES;
    end else begin
      case (b) inside
        ucpe_pkg::CH_DASH, ucpe_pkg::CH_DOT, ucpe_pkg::CH_US, ucpe_pkg::CH_TILDE: begin
          c = CLS_UNRES;
        end
        ucpe_pkg::CH_PCT: begin
          c = CLS_PCT;
        end
        ucpe_pkg::CH_COLON, ucpe_pkg::CH_SLASH, ucpe_pkg::CH_QMARK, ucpe_pkg::CH_HASH,
        ucpe_pkg::CH_LBRACK, ucpe_pkg::CH_RBRACK, ucpe_pkg::CH_AT: begin
          c = CLS_GEN;
        end
        ucpe_pkg::CH_BANG, ucpe_pkg::CH_DOLLAR, ucpe_pkg::CH_AMP, ucpe_pkg::CH_APOS,
        ucpe_pkg::CH_LPAREN, ucpe_pkg::CH_RPAREN, ucpe_pkg::CH_STAR, ucpe_pkg::CH_PLUS,
        ucpe_pkg::CH_COMMA, ucpe_pkg::CH_SEMI, ucpe_pkg::CH_EQUAL: begin
          c = CLS_SUB;
        end
        default: begin
          c = CLS_OTHER;
        end
      endcase
    end
    return c;
  endfunction

  // upper-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? {4'h3, n} : (8'h37 + {4'h0, n});
  endfunction

  logic [7:0]                 in_byte;
  logic                       first_of_part;
  logic                       lead_slash;
  logic                       end_of_uri;
  logic                       error_seen;
  logic                       illegal;
  logic                       err_after;
  logic                       pre_v;
  logic [7:0]                 pre_b;
  body_t                      body;
  suf_t                       suf;
  class_t                     cls;
  logic [ucpe_pkg::PUSH_CNT_W-1:0] k;
  logic [ucpe_pkg::MAX_PUSH-1:0][7:0] plist;
  logic                       accept;

  assign in_byte       = s_tdata[7:0];
  assign first_of_part = s_tdata[8];
  assign lead_slash    = s_tdata[9];
  assign end_of_uri    = s_tdata[10];

  assign s_tready = wr_ready;
  assign wr_valid = s_tvalid;
  assign accept   = s_tvalid && wr_ready;

  // classification per component kind
  always_comb begin
    cls     = byte_class(in_byte);
    illegal = 1'b0;
    pre_v   = 1'b0;
    pre_b   = ucpe_pkg::CH_SLASH;
    body    = BODY_ONE;
    suf     = SUF_NONE;
    case (s_tuser)
      ucpe_pkg::FUNC_SCHEME: begin
        if (first_of_part ? ucpe_pkg::is_letter(in_byte)
                          : (ucpe_pkg::is_letter(in_byte) || ucpe_pkg::is_digit(in_byte) ||
                             in_byte == ucpe_pkg::CH_PLUS || in_byte == ucpe_pkg::CH_DASH ||
                             in_byte == ucpe_pkg::CH_DOT)) begin
          body = BODY_ONE;
        end else begin
          body    = BODY_NONE;
          illegal = 1'b1;
        end
        if (s_tlast) begin
          suf = SUF_SCHEME;
        end
      end
      ucpe_pkg::FUNC_USERINFO: begin
        if (cls == CLS_OTHER) begin
          body = BODY_HEX;
        end else if (cls == CLS_GEN && in_byte != ucpe_pkg::CH_COLON) begin
          body    = BODY_NONE;
          illegal = 1'b1;
        end
        if (s_tlast) begin
          suf = SUF_AT;
        end
      end
      ucpe_pkg::FUNC_PORT: begin
        pre_v = first_of_part;
        pre_b = ucpe_pkg::CH_COLON;
        if (!ucpe_pkg::is_digit(in_byte)) begin
          body    = BODY_NONE;
          illegal = 1'b1;
        end
      end
      ucpe_pkg::FUNC_PATH: begin
        pre_v = first_of_part && lead_slash;
        pre_b = ucpe_pkg::CH_SLASH;
        if (cls == CLS_OTHER) begin
          body = BODY_HEX;
        end else if (cls == CLS_GEN) begin
          if (in_byte == ucpe_pkg::CH_QMARK || in_byte == ucpe_pkg::CH_HASH) begin
            body    = BODY_NONE;
            illegal = 1'b1;
          end else if (in_byte != ucpe_pkg::CH_SLASH) begin
            body = BODY_HEX;  // : [ ] @ escaped
          end
        end
      end
      ucpe_pkg::FUNC_QUERY: begin
        pre_v = first_of_part;
        pre_b = ucpe_pkg::CH_QMARK;
        if (cls == CLS_OTHER) begin
          body = BODY_HEX;
        end else if (in_byte == ucpe_pkg::CH_HASH) begin
          body    = BODY_NONE;
          illegal = 1'b1;
        end
      end
      ucpe_pkg::FUNC_FRAGMENT: begin
        pre_v = first_of_part;
        pre_b = ucpe_pkg::CH_HASH;
        if (cls == CLS_OTHER) begin
          body = BODY_HEX;
        end
      end
      default: begin
        // unknown kind: illegal, no separators
        body    = BODY_NONE;
        illegal = 1'b1;
      end
    endcase
  end

  // pack prefix, body and suffix into the push list
  always_comb begin
    k     = '0;
    plist = '0;
    if (pre_v) begin
      plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = pre_b;
      k = k + 1'b1;
    end
    case (body)
      BODY_ONE: begin
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = in_byte;
        k = k + 1'b1;
      end
      BODY_HEX: begin
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = ucpe_pkg::CH_PCT;
        k = k + 1'b1;
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = hex_char(in_byte[7:4]);
        k = k + 1'b1;
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = hex_char(in_byte[3:0]);
        k = k + 1'b1;
      end
      default: begin
      end
    endcase
    case (suf)
      SUF_SCHEME: begin
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = ucpe_pkg::CH_COLON;
        k = k + 1'b1;
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = ucpe_pkg::CH_SLASH;
        k = k + 1'b1;
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = ucpe_pkg::CH_SLASH;
        k = k + 1'b1;
      end
      SUF_AT: begin
        plist[k[ucpe_pkg::PUSH_IDX_W-1:0]] = ucpe_pkg::CH_AT;
        k = k + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign err_after     = error_seen || illegal;
  assign wr_data.bytes = plist;
  assign wr_data.count = k;
  assign wr_data.eou   = end_of_uri;
  assign wr_data.bad   = err_after;

  // sticky error, cleared at end of URI
  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen <= 1'b0;
    end else if (accept) begin
      error_seen <= end_of_uri ? 1'b0 : err_after;
    end
  end

endmodule

`default_nettype wire

FILE: design/ucpe_queue.sv
// Short register queue of push lists between front and back.
// Depends on ucpe_pkg for the entry type and depth.
`default_nettype none

module ucpe_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_valid,
  output logic                       wr_ready,
  input  wire ucpe_pkg::push_list_t  wr_data,
  output logic                       rd_valid,
  input  wire logic                  rd_ready,
  output ucpe_pkg::push_list_t       rd_data
);

  ucpe_pkg::push_list_t              mem [ucpe_pkg::QDEPTH];
  logic [ucpe_pkg::QPTR_W-1:0]       wptr;
  logic [ucpe_pkg::QPTR_W-1:0]       rptr;
  logic [ucpe_pkg::QCNT_W-1:0]       count;
  logic                              do_wr;
  logic                              do_rd;

  assign wr_ready = (count != ucpe_pkg::QCNT_W'(ucpe_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/ucpe_back.sv
// Back part: runs each push list through the %xy hold window, flushes at end of URI,
// serializes output bytes one per cycle while m_tready is high. Depends on ucpe_pkg.
`default_nettype none

module ucpe_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_valid,
  output logic                       rd_ready,
  input  wire ucpe_pkg::push_list_t  rd_data,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,  // out_byte
  output logic                       m_tlast,  // run_last
  output logic [1:0]                 m_tuser   // uri_done, bad_uri
);

  typedef enum logic [1:0] {
    HOLD_EMPTY,
    HOLD_PCT,
    HOLD_PAIR
  } hold_t;

  typedef struct packed {
    hold_t           cnt;
    logic [7:0]      h1;
    logic [1:0]      n;
    logic [2:0][7:0] e;
  } push_res_t;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
  endfunction

  // one byte into the hold window; the held first byte is always '%'
  function automatic push_res_t push_step(input hold_t cnt, input logic [7:0] h1,
                                          input logic [7:0] b);
    push_res_t r;
    r     = '0;
    r.cnt = cnt;
    r.h1  = h1;
    unique case (cnt)
      HOLD_EMPTY: begin
        if (b == ucpe_pkg::CH_PCT) begin
          r.cnt = HOLD_PCT;
        end else begin
          r.n    = 2'd1;
          r.e[0] = b;
        end
      end
      HOLD_PCT: begin
        r.h1  = b;
        r.cnt = HOLD_PAIR;
      end
      HOLD_PAIR: begin
        r.e[0] = ucpe_pkg::CH_PCT;
        r.cnt  = HOLD_EMPTY;
        if (ucpe_pkg::is_letter(h1) && ucpe_pkg::is_letter(b)) begin
          r.e[1] = upcase(h1);
          r.e[2] = upcase(b);
          r.n    = 2'd3;
        end else if (h1 == ucpe_pkg::CH_PCT) begin
          // "%%b": second % opens a new window holding b
          r.cnt = HOLD_PAIR;
          r.h1  = b;
          r.n   = 2'd1;
        end else begin
          r.e[1] = h1;
          if (b == ucpe_pkg::CH_PCT) begin
            r.cnt = HOLD_PCT;
            r.n   = 2'd2;
          end else begin
            r.e[2] = b;
            r.n    = 2'd3;
          end
        end
      end
      default: begin
        r.cnt = HOLD_EMPTY;
      end
    endcase
    return r;
  endfunction

  hold_t                               hold_cnt;
  logic [7:0]                          hold_h1;
  hold_t                               hc;
  logic [7:0]                          h1;
  push_res_t                           pr;
  logic [ucpe_pkg::OUT_CNT_W-1:0]      k;
  logic [ucpe_pkg::MAX_OUT-1:0][7:0]   lst;
  logic [ucpe_pkg::MAX_OUT-1:0][7:0]   obuf;
  logic [ucpe_pkg::OUT_CNT_W-1:0]      rem;
  logic                                cur_eou;
  logic                                cur_bad;
  logic                                out_free;
  logic                                shift;
  logic                                load;
  logic                                rem_one;

  // expand one push list into its output bytes
  always_comb begin
    hc  = hold_cnt;
    h1  = hold_h1;
    k   = '0;
    lst = '0;
    pr  = '0;
    for (int i = 0; i < ucpe_pkg::MAX_PUSH; i++) begin
      if (ucpe_pkg::PUSH_CNT_W'(i) < rd_data.count) begin
        pr = push_step(hc, h1, rd_data.bytes[i]);
        hc = pr.cnt;
        h1 = pr.h1;
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < pr.n) begin
            lst[k[ucpe_pkg::OUT_IDX_W-1:0]] = pr.e[j];
            k = k + 1'b1;
          end
        end
      end
    end
    if (rd_data.eou) begin
      // flush held bytes unchanged
      if (hc != HOLD_EMPTY) begin
        lst[k[ucpe_pkg::OUT_IDX_W-1:0]] = ucpe_pkg::CH_PCT;
        k = k + 1'b1;
      end
      if (hc == HOLD_PAIR) begin
        lst[k[ucpe_pkg::OUT_IDX_W-1:0]] = h1;
        k = k + 1'b1;
      end
      hc = HOLD_EMPTY;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign rem_one  = (rem == ucpe_pkg::OUT_CNT_W'(1));
  assign shift    = (rem != '0) && out_free;
  assign rd_ready = (rem == '0) || (rem_one && out_free);
  assign load     = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem      <= '0;
      m_tvalid <= 1'b0;
      hold_cnt <= HOLD_EMPTY;
    end else begin
      if (out_free) begin
        m_tvalid <= (rem != '0);
      end
      if (load) begin
        rem      <= k;
        hold_cnt <= hc;
      end else if (shift) begin
        rem <= rem - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      m_tdata <= obuf[0];
      m_tlast <= rem_one;
      m_tuser <= {cur_bad, rem_one && cur_eou};
    end
    if (load) begin
      obuf    <= lst;
      cur_eou <= rd_data.eou;
      cur_bad <= rd_data.bad;
      hold_h1 <= h1;
    end else if (shift) begin
      obuf <= {8'h00, obuf[ucpe_pkg::MAX_OUT-1:1]};
    end
  end

endmodule

`default_nettype wire

FILE: tb/uri_component_percent_encoder_core_tb.sv
`timescale 1ns / 100ps
// Testbench for uri_component_percent_encoder_core: directed and random URI byte streams
// checked against an in-bench encoder model. Depends on ucpe_pkg and the RTL.

module uri_component_percent_encoder_core_tb;
  import ucpe_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int CALM_TAIL    = 20;
  localparam int RANDOM_ITEMS = 74;

  // component kinds with no meaning, treated as illegal
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum int {
    KIND_OTHER,
    KIND_UNRESERVED,
    KIND_PERCENT,
    KIND_GEN_DELIM,
    KIND_SUB_DELIM
  } char_kind_t;

  // one source byte with its marks
  typedef struct {
    logic [2:0] func;
    logic [7:0] raw;
    logic       first;
    logic       last;
    logic       slash;
    logic       eou;
  } src_byte_t;

  // one encoded output character
  typedef struct {
    logic [7:0] chr;
    logic       run_last;
    logic       done;
    logic       bad;
  } enc_char_t;

  // Encoder model plus the queue of characters still owed by the block.
  class uri_encode_board;
    logic       err_flag;
    logic [7:0] hold_buf [2];
    int         hold_n;
    logic [7:0] step_chars [$];
    enc_char_t  pending_chars [$];
    int         mismatch_count;

    function new();
      err_flag = 1'b0;
      hold_buf[0] = 8'h00;
      hold_buf[1] = 8'h00;
      hold_n = 0;
      mismatch_count = 0;
    endfunction

    function logic alpha(logic [7:0] b);
      return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z);
    endfunction

    function logic digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function logic [7:0] upcase(logic [7:0] b);
      return (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CH_LOWER_A + CH_UPPER_A : b;
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
      return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_UPPER_A + 8'(n) - 8'd10;
    endfunction

    function char_kind_t kind_of(logic [7:0] b);
      if (alpha(b) || digit(b))
        return KIND_UNRESERVED;
      case (b)
        CH_DASH, CH_DOT, CH_US, CH_TILDE: return KIND_UNRESERVED;
        CH_PCT: return KIND_PERCENT;
        CH_COLON, CH_SLASH, CH_QMARK, CH_HASH, CH_LBRACK, CH_RBRACK, CH_AT:
          return KIND_GEN_DELIM;
        CH_BANG, CH_DOLLAR, CH_AMP, CH_APOS, CH_LPAREN, CH_RPAREN,
        CH_STAR, CH_PLUS, CH_COMMA, CH_SEMI, CH_EQUAL:
          return KIND_SUB_DELIM;
        default: return KIND_OTHER;
      endcase
    endfunction

    function void emit_char(logic [7:0] b);
      if (step_chars.size() < MAX_OUT)
        step_chars.push_back(b);
    endfunction

    // Hold window: '%' and the next byte wait for a third; %xy is upper-cased only
    // when x and y are both letters, else the held bytes are replayed in order.
    function void push_char(logic [7:0] b);
      logic [7:0] work [$];
      logic [7:0] c;
      logic [7:0] x;
      work.push_back(b);
      while (work.size() > 0) begin
        c = work.pop_front();
        if (hold_n == 0) begin
          if (c == CH_PCT) begin
            hold_buf[0] = c;
            hold_n = 1;
          end else begin
            emit_char(c);
          end
        end else if (hold_n == 1) begin
          hold_buf[1] = c;
          hold_n = 2;
        end else begin
          x = hold_buf[1];
          hold_n = 0;
          emit_char(CH_PCT);
          if (alpha(x) && alpha(c)) begin
            emit_char(upcase(x));
            emit_char(upcase(c));
          end else begin
            work.push_front(c);
            work.push_front(x);
          end
        end
      end
    endfunction

    function void push_escaped(logic [7:0] b);
      push_char(CH_PCT);
      push_char(hex_char(b[7:4]));
      push_char(hex_char(b[3:0]));
    endfunction

    // Encode one accepted source byte and queue the characters it owes.
    function void accept_source_byte(src_byte_t it);
      char_kind_t k;
      enc_char_t  r;
      logic       ok;
      k = kind_of(it.raw);
      step_chars.delete();
      case (it.func)
        FUNC_SCHEME: begin
          if (it.first)
            ok = alpha(it.raw);
          else
            ok = alpha(it.raw) || digit(it.raw) || it.raw == CH_PLUS ||
                 it.raw == CH_DASH || it.raw == CH_DOT;
          if (ok)
            push_char(it.raw);
          else
            err_flag = 1'b1;
          if (it.last) begin
            push_char(CH_COLON);
            push_char(CH_SLASH);
            push_char(CH_SLASH);
          end
        end
        FUNC_USERINFO: begin
          if (k == KIND_OTHER)
            push_escaped(it.raw);
          else if (k == KIND_GEN_DELIM && it.raw != CH_COLON)
            err_flag = 1'b1;
          else
            push_char(it.raw);
          if (it.last)
            push_char(CH_AT);
        end
        FUNC_PORT: begin
          if (it.first)
            push_char(CH_COLON);
          if (digit(it.raw))
            push_char(it.raw);
          else
            err_flag = 1'b1;
        end
        FUNC_PATH: begin
          if (it.first && it.slash)
            push_char(CH_SLASH);
          if (k == KIND_OTHER) begin
            push_escaped(it.raw);
          end else if (k == KIND_GEN_DELIM) begin
            if (it.raw == CH_QMARK || it.raw == CH_HASH)
              err_flag = 1'b1;
            else if (it.raw == CH_SLASH)
              push_char(it.raw);
            else
              push_escaped(it.raw);
          end else begin
            push_char(it.raw);
          end
        end
        FUNC_QUERY: begin
          if (it.first)
            push_char(CH_QMARK);
          if (k == KIND_OTHER)
            push_escaped(it.raw);
          else if (it.raw == CH_HASH)
            err_flag = 1'b1;
          else
            push_char(it.raw);
        end
        FUNC_FRAGMENT: begin
          if (it.first)
            push_char(CH_HASH);
          if (k == KIND_OTHER)
            push_escaped(it.raw);
          else
            push_char(it.raw);
        end
        default: err_flag = 1'b1;
      endcase

      if (it.eou) begin
        for (int i = 0; i < hold_n; i++)
          emit_char(hold_buf[i]);
        hold_n = 0;
      end

      for (int i = 0; i < step_chars.size(); i++) begin
        r.chr      = step_chars[i];
        r.run_last = (i == step_chars.size() - 1);
        r.done     = r.run_last && it.eou;
        r.bad      = err_flag;
        pending_chars.push_back(r);
      end

      if (it.eou) begin
        err_flag = 1'b0;
        hold_buf[0] = 8'h00;
        hold_buf[1] = 8'h00;
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
    endtask

    task check_encoded_char(enc_char_t got);
      enc_char_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last=%b done=%b bad=%b",
                                  got.chr, got.run_last, got.done, got.bad));
        return;
      end
      want = pending_chars.pop_front();
      if (got.chr !== want.chr || got.run_last !== want.run_last ||
          got.done !== want.done || got.bad !== want.bad)
        report_mismatch($sformatf("got %h/%b/%b/%b want %h/%b/%b/%b (char/last/done/bad)",
                                  got.chr, got.run_last, got.done, got.bad,
                                  want.chr, want.run_last, want.done, want.bad));
    endtask

    task close_out();
      if (pending_chars.size() != 0)
        report_mismatch($sformatf("%0d chars never came out", pending_chars.size()));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  uri_encode_board board;
  src_byte_t       stim [$];
  bit              calm;        // no idling on either side in the tail of the run
  int              cycle_count;
  enc_char_t       seen_char;

  uri_component_percent_encoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // in_byte[7:0], first_of_part[8], lead_slash[9], end_of_uri[10]
    .s_tlast  (s_tlast),   // last_of_part
    .s_tuser  (s_tuser),   // func
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_byte[7:0]
    .m_tlast  (m_tlast),   // run_last
    .m_tuser  (m_tuser)    // uri_done[0], bad_uri[1]
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run watchdog: covers worst-case stalls many times over.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sink side: ready drops at random in bursts, none in the tail.
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Output monitor: every accepted output transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_char.chr      = m_tdata;
      seen_char.run_last = m_tlast;
      seen_char.done     = m_tuser[0];
      seen_char.bad      = m_tuser[1];
      board.check_encoded_char(seen_char);
    end
  end

  function automatic src_byte_t make_item(logic [2:0] func, logic [7:0] raw, logic first,
                                          logic last, logic slash, logic eou);
    src_byte_t it;
    it.func  = func;
    it.raw   = raw;
    it.first = first;
    it.last  = last;
    it.slash = slash;
    it.eou   = eou;
    return it;
  endfunction

  // Mostly characters the component accepts, with some '%' and some arbitrary bytes.
  function automatic logic [7:0] component_char(logic [2:0] func, logic first);
    string pool;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 12)
      return CH_PCT;
    if (r < 24)
      return 8'($urandom_range(0, 255));
    case (func)
      FUNC_SCHEME: begin
        if (first)
          pool = "abhpstxzABHPSZ";
        else
          pool = "ahtpsz09AZ+-.";
      end
      FUNC_USERINFO: pool = "auzAZ09-._~:!$&'()*+,;=";
      FUNC_PORT:     pool = "0123456789";
      FUNC_PATH:     pool = "aeFzZ09-._~/!$&=+,;:@[]";
      FUNC_QUERY:    pool = "aqzQ09-._~/?:@!$&'=+";
      default:       pool = "afzF09-._~/?:@#!$=+";
    endcase
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // One URI: components in order, each present at random, marks mostly right.
  function automatic void append_uri();
    src_byte_t it;
    int        len;
    int        start;
    start = stim.size();
    for (int f = 0; f <= 5; f++) begin
      if ($urandom_range(0, 99) < 55 || (f == 5 && stim.size() == start)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        for (int n = 0; n < len; n++) begin
          it.func  = 3'(f);
          it.first = (n == 0);
          it.last  = (n == len - 1);
          it.slash = 1'($urandom_range(0, 1));
          it.eou   = 1'b0;
          it.raw   = component_char(it.func, it.first);
          // broken sequences: a mark now and then lost or misplaced
          if ($urandom_range(0, 19) == 0)
            it.first = ~it.first;
          if ($urandom_range(0, 19) == 0)
            it.last = ~it.last;
          stim.push_back(it);
        end
      end
    end
    stim[stim.size() - 1].eou = 1'b1;
  endfunction

  task automatic drive_source(src_byte_t it, int gap);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, it.eou, it.slash, it.first, it.raw};
    s_tlast  <= it.last;
    s_tuser  <= it.func;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    board.accept_source_byte(it);
  endtask

  initial begin
    int directed_n;
    int gap;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    s_tuser  = '0;
    calm     = 1'b0;
    board    = new();

    // directed: separators, escapes at both byte extremes, an illegal case for every kind that has one,
    // the hold window both ways, the end-of-URI flush and an empty final step
    stim.push_back(make_item(FUNC_SCHEME,   8'h68,     1, 0, 0, 0)); // h
    stim.push_back(make_item(FUNC_SCHEME,   8'h74,     0, 1, 1, 0)); // t then ://
    stim.push_back(make_item(FUNC_SCHEME,   8'h31,     1, 1, 0, 0)); // digit first: illegal
    stim.push_back(make_item(FUNC_USERINFO, 8'h00,     1, 0, 0, 0)); // %00
    stim.push_back(make_item(FUNC_USERINFO, 8'hFF,     0, 0, 1, 0)); // %FF
    stim.push_back(make_item(FUNC_USERINFO, CH_COLON,  0, 0, 0, 0));
    stim.push_back(make_item(FUNC_USERINFO, CH_AT,     0, 1, 0, 0)); // illegal, @ still out
    stim.push_back(make_item(FUNC_PORT,     8'h38,     1, 0, 0, 0)); // :8
    stim.push_back(make_item(FUNC_PORT,     8'h78,     0, 1, 0, 1)); // x illegal, end of URI
    stim.push_back(make_item(FUNC_PATH,     8'h20,     1, 0, 1, 0)); // /%20
    stim.push_back(make_item(FUNC_PATH,     CH_QMARK,  0, 0, 0, 0)); // illegal in path
    stim.push_back(make_item(FUNC_PATH,     CH_LBRACK, 0, 0, 0, 0)); // escaped
    stim.push_back(make_item(FUNC_PATH,     CH_SLASH,  0, 0, 0, 0));
    stim.push_back(make_item(FUNC_PATH,     CH_PCT,    0, 0, 0, 0)); // held
    stim.push_back(make_item(FUNC_PATH,     8'h61,     0, 0, 0, 0)); // held
    stim.push_back(make_item(FUNC_PATH,     8'h62,     0, 0, 0, 0)); // %AB
    stim.push_back(make_item(FUNC_PATH,     CH_PCT,    0, 0, 0, 0));
    stim.push_back(make_item(FUNC_PATH,     8'h34,     0, 0, 0, 0));
    stim.push_back(make_item(FUNC_PATH,     8'h7A,     0, 1, 0, 0)); // %4z unchanged
    stim.push_back(make_item(FUNC_QUERY,    CH_HASH,   1, 0, 0, 0)); // ? out, # illegal
    stim.push_back(make_item(FUNC_QUERY,    CH_AT,     0, 1, 0, 0));
    stim.push_back(make_item(FUNC_FRAGMENT, CH_HASH,   1, 0, 0, 0)); // ##
    stim.push_back(make_item(FUNC_UNUSED_LO, 8'h41,    1, 1, 1, 0)); // unknown kind
    stim.push_back(make_item(FUNC_FRAGMENT, CH_PCT,    0, 0, 0, 0));
    stim.push_back(make_item(FUNC_FRAGMENT, 8'h71,     0, 1, 0, 1)); // flush %q
    stim.push_back(make_item(FUNC_UNUSED_HI, 8'h00,    0, 0, 0, 1)); // no output at all
    directed_n = stim.size();

    // random: URIs with random content and mostly right marks, some noise between them
    while (stim.size() < directed_n + RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 3))
          stim.push_back(make_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0)));
      end
      append_uri();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim[i]) begin
      calm = (i >= stim.size() - CALM_TAIL);
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      drive_source(stim[i], gap);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (board.pending_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();

    if (board.mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
design/ucpe_pkg.sv
design/ucpe_front.sv
design/ucpe_queue.sv
design/ucpe_back.sv
design/uri_component_percent_encoder_core.sv
tb/uri_component_percent_encoder_core_tb.sv
